FILE: sv/fcm_pkg.sv
// Shared constants, register codes and configuration types of the fuzzy c-means membership block.
`timescale 1ns / 1ps

package fcm_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_CLASSES_DEF  = 4;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // Fixed layout of ports and registers.
  localparam int NUM_MEANS      = 4;
  localparam int NUM_PORTS      = 4;
  localparam int PORT_BITS      = 16;
  localparam int MEAN_LANE_BITS = 16;
  localparam int CFG_DATA_BITS  = NUM_MEANS * MEAN_LANE_BITS;
  localparam int CFG_IDX_BITS   = 3;
  localparam int COUNT_BITS     = 3;

  // Reset values of the count registers.
  localparam logic [COUNT_BITS-1:0] CLASS_COUNT_RST   = 3'd3;
  localparam logic [COUNT_BITS-1:0] CHANNEL_COUNT_RST = 3'd1;

  // Bit positions in the divider tag of a ratio lane.
  localparam int TAG_SAT  = 0;
  localparam int TAG_ZERO = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLASS_COUNT   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_MEAN_A        = 3'd2,
    REG_MEAN_B        = 3'd3,
    REG_MEAN_C        = 3'd4,
    REG_MEAN_D        = 3'd5
  } reg_idx_t;

  // Clamped counts that the datapath works with.
  typedef struct packed {
    logic [COUNT_BITS-1:0] cls_cnt;
    logic [COUNT_BITS-1:0] chan_cnt;
  } cfg_t;

endpackage

FILE: sv/fcm_dist.sv
// Per-class distance lanes: squared Euclidean distance from the sample to each class mean.
`timescale 1ns / 1ps

module fcm_dist
  import fcm_pkg::*;
#(
  parameter int NL  = 4,
  parameter int NCH = 4,
  parameter int SB  = 16,
  parameter int DW  = 2 * SB + $clog2(NCH)
) (
  input  logic                     clk,
  input  logic                     en,
  input  cfg_t                     cfg,
  input  logic [SB-1:0]            smp [NCH],
  input  logic [CFG_DATA_BITS-1:0] mean [NL],
  output logic [DW-1:0]            dist_r [NL]
);

  logic signed [SB:0]     diff_r   [NL][NCH];
  logic signed [SB:0]     diff_nxt [NL][NCH];
  logic        [2*SB-1:0] sq_r     [NL][NCH];
  logic        [2*SB-1:0] sq_nxt   [NL][NCH];
  logic        [DW-1:0]   dist_nxt [NL];

  // Stage one: channel differences, sign-extended by one bit.
  always_comb begin
    logic [SB-1:0] m;
    for (int c = 0; c < NL; c++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        m = mean[c][ch*MEAN_LANE_BITS +: SB];
        diff_nxt[c][ch] = $signed({smp[ch][SB-1], smp[ch]}) - $signed({m[SB-1], m});
      end
    end
  end

  // Stage two: squares, with unused channels forced to zero.
  always_comb begin
    logic signed [2*SB+1:0] prod;
    for (int c = 0; c < NL; c++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        prod = diff_r[c][ch] * diff_r[c][ch];
        sq_nxt[c][ch] = (ch < int'(cfg.chan_cnt)) ? prod[2*SB-1:0] : '0;
      end
    end
  end

  // Stage three: sum of the channel squares.
  always_comb begin
    for (int c = 0; c < NL; c++) begin
      dist_nxt[c] = '0;
      for (int ch = 0; ch < NCH; ch++) begin
        dist_nxt[c] = dist_nxt[c] + DW'(sq_r[c][ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      sq_r   <= sq_nxt;
      dist_r <= dist_nxt;
    end
  end

endmodule

FILE: sv/fcm_div.sv
// Pipelined restoring divider that settles one quotient bit per stage.
`timescale 1ns / 1ps

module fcm_div #(
  parameter int NW  = 48,
  parameter int DNW = 34,
  parameter int QB  = 32,
  parameter int TW  = 2
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  input  logic [TW-1:0]  tag_in,
  output logic [QB-1:0]  quo,
  output logic [TW-1:0]  tag_out
);

  localparam int XW = (NW > DNW + QB) ? NW : DNW + QB;

  logic [XW-1:0]  rem_r [QB];
  logic [DNW-1:0] den_r [QB];
  logic [QB-1:0]  q_r   [QB];
  logic [TW-1:0]  tag_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int SH = QB - 1 - j;
    logic [XW-1:0]  rem_in;
    logic [DNW-1:0] den_in;
    logic [QB-1:0]  q_in;
    logic [TW-1:0]  tag_now;
    logic [XW-1:0]  den_sh;
    logic [XW-1:0]  rem_nxt;
    logic [QB-1:0]  q_nxt;
    logic           ge;

    // Stage inputs come from the ports for the first stage, else from the stage before.
    if (j == 0) begin : g_first
      assign rem_in  = XW'(num);
      assign den_in  = den;
      assign q_in    = '0;
      assign tag_now = tag_in;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign tag_now = tag_r[j-1];
    end

    // Trial subtraction of the shifted divisor.
    always_comb begin
      den_sh  = XW'(den_in) << SH;
      ge      = (rem_in >= den_sh);
      rem_nxt = ge ? (rem_in - den_sh) : rem_in;
      q_nxt   = q_in;
      q_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_in;
        q_r[j]   <= q_nxt;
        tag_r[j] <= tag_now;
      end
    end
  end

  assign quo     = q_r[QB-1];
  assign tag_out = tag_r[QB-1];

endmodule

FILE: sv/fcm_merge.sv
// Merging stage: sums the distance ratios of each class over all classes in use.
`timescale 1ns / 1ps

module fcm_merge
  import fcm_pkg::*;
#(
  parameter int NL = 4,
  parameter int F  = 16,
  parameter int SW = 2 * F + 1 + $clog2(NL)
) (
  input  logic          clk,
  input  logic          en,
  input  cfg_t          cfg,
  input  logic [2*F-1:0] quo [NL][NL],
  input  logic [1:0]    tag [NL][NL],
  output logic [SW-1:0] sum_r [NL]
);

  localparam int RW = 2 * F + 1;

  logic [SW-1:0] sum_nxt [NL];

  // A zero numerator gives zero, a saturated ratio gives the cap, else the quotient.
  always_comb begin
    logic [RW-1:0] ratio;
    for (int c = 0; c < NL; c++) begin
      sum_nxt[c] = SW'(1);
      for (int k = 0; k < NL; k++) begin
        if (tag[c][k][TAG_ZERO]) begin
          ratio = '0;
        end else if (tag[c][k][TAG_SAT]) begin
          ratio = RW'(1) << (2 * F);
        end else begin
          ratio = RW'(quo[c][k]);
        end
        if (k < int'(cfg.cls_cnt)) begin
          sum_nxt[c] = sum_nxt[c] + SW'(ratio);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: sv/fuzzy_cmeans_membership_top.sv
// Top level of the fuzzy c-means membership block (fuzzifier two).
`timescale 1ns / 1ps

// Fuzzy c-means membership, one voxel word per clock. Each accepted word with in_mask set
// yields one result word after three distance stages, 2*FRAC_BITS ratio divider stages, one
// merge stage, FRAC_BITS final divider stages and the output register. A word with in_mask
// clear yields no result. The sustained rate, while the output is not stalled, is one word per
// cycle, set by the fully pipelined dividers of every class pair. When the output word is
// stalled, the whole pipeline holds once its last stage is full; until then every stage
// still moves and empty stages close up. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data and must only change while no word is in flight.
module fuzzy_cmeans_membership_top
  import fcm_pkg::*;
#(
  parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [PORT_BITS-1:0] in_sample_zero,
  input  logic signed [PORT_BITS-1:0] in_sample_one,
  input  logic signed [PORT_BITS-1:0] in_sample_two,
  input  logic signed [PORT_BITS-1:0] in_sample_three,
  input  logic                     in_mask,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FRAC_BITS:0]       out_member_zero,
  output logic [FRAC_BITS:0]       out_member_one,
  output logic [FRAC_BITS:0]       out_member_two,
  output logic [FRAC_BITS:0]       out_member_three
);

  localparam int F   = FRAC_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int NCH = MAX_CHANNELS;
  localparam int NL  = (MAX_CLASSES < NUM_MEANS) ? MAX_CLASSES : NUM_MEANS;
  localparam int DW  = 2 * SB + $clog2(NCH);
  localparam int NW  = DW + F;
  localparam int SW  = 2 * F + 1 + $clog2(NL);
  localparam int LAT = 3 * F + 4;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  // Configuration registers.
  logic [COUNT_BITS-1:0]    class_count_r;
  logic [COUNT_BITS-1:0]    channel_count_r;
  logic [CFG_DATA_BITS-1:0] mean_r [NUM_MEANS];
  cfg_t                     cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r   <= CLASS_COUNT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
      for (int i = 0; i < NUM_MEANS; i++) begin
        mean_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CLASS_COUNT:   class_count_r   <= cfg_data[COUNT_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[COUNT_BITS-1:0];
        REG_MEAN_A:        mean_r[0]       <= cfg_data;
        REG_MEAN_B:        mean_r[1]       <= cfg_data;
        REG_MEAN_C:        mean_r[2]       <= cfg_data;
        REG_MEAN_D:        mean_r[3]       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the counts into the range the lanes cover.
  always_comb begin
    if (class_count_r == '0) begin
      cfg.cls_cnt = COUNT_BITS'(1);
    end else if (int'(class_count_r) > NL) begin
      cfg.cls_cnt = COUNT_BITS'(NL);
    end else begin
      cfg.cls_cnt = class_count_r;
    end
    if (channel_count_r == '0) begin
      cfg.chan_cnt = COUNT_BITS'(1);
    end else if (int'(channel_count_r) > NCH) begin
      cfg.chan_cnt = COUNT_BITS'(NCH);
    end else begin
      cfg.chan_cnt = channel_count_r;
    end
  end

  // Pipeline flow: everything moves unless a full last stage meets a stalled output word.
  logic [LAT-1:0] vld_r;
  logic           adv;
  logic           out_load;
  logic           out_valid_r;

  assign adv      = !out_valid_r || !out_stall || !vld_r[LAT-1];
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid & in_mask};
    end
  end

  // Sample lanes.
  logic [PORT_BITS-1:0] port_smp [NUM_PORTS];
  logic [SB-1:0]        smp      [NCH];
  logic [CFG_DATA_BITS-1:0] lane_mean [NL];

  assign port_smp[0] = in_sample_zero;
  assign port_smp[1] = in_sample_one;
  assign port_smp[2] = in_sample_two;
  assign port_smp[3] = in_sample_three;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      smp[ch] = port_smp[ch][SB-1:0];
    end
    for (int c = 0; c < NL; c++) begin
      lane_mean[c] = mean_r[c];
    end
  end

  logic [DW-1:0] cls_dist [NL];

  fcm_dist #(
    .NL (NL),
    .NCH(NCH),
    .SB (SB),
    .DW (DW)
  ) u_dist (
    .clk   (clk),
    .en    (adv),
    .cfg   (cfg),
    .smp   (smp),
    .mean  (lane_mean),
    .dist_r(cls_dist)
  );

  // Ratio lanes: one divider for every pair of classes.
  logic [2*F-1:0] rq   [NL][NL];
  logic [1:0]     rtag [NL][NL];

  for (genvar c = 0; c < NL; c++) begin : g_row
    for (genvar k = 0; k < NL; k++) begin : g_col
      logic [1:0] tag_in;

      always_comb begin
        tag_in[TAG_ZERO] = (cls_dist[c] == '0);
        tag_in[TAG_SAT]  = (NW'(cls_dist[c]) >= (NW'(cls_dist[k]) << F));
      end

      fcm_div #(
        .NW (NW),
        .DNW(DW),
        .QB (2 * F),
        .TW (2)
      ) u_ratio (
        .clk    (clk),
        .en     (adv),
        .num    (NW'(cls_dist[c]) << F),
        .den    (cls_dist[k]),
        .tag_in (tag_in),
        .quo    (rq[c][k]),
        .tag_out(rtag[c][k])
      );
    end
  end

  logic [SW-1:0] sum [NL];

  fcm_merge #(
    .NL(NL),
    .F (F),
    .SW(SW)
  ) u_merge (
    .clk  (clk),
    .en   (adv),
    .cfg  (cfg),
    .quo  (rq),
    .tag  (rtag),
    .sum_r(sum)
  );

  // Final reciprocal lanes; a sum at or below one saturates the membership to one.
  logic [F-1:0] uq   [NL];
  logic         usat [NL];
  logic [F:0]   mem_nxt [NUM_MEANS];

  for (genvar c = 0; c < NL; c++) begin : g_recip
    logic sat_in;
    logic sat_out;

    assign sat_in  = (sum[c] <= (SW'(1) << F));
    assign usat[c] = sat_out;

    fcm_div #(
      .NW (2 * F + 1),
      .DNW(SW),
      .QB (F),
      .TW (1)
    ) u_recip (
      .clk    (clk),
      .en     (adv),
      .num    ((2 * F + 1)'(1) << (2 * F)),
      .den    (sum[c]),
      .tag_in (sat_in),
      .quo    (uq[c]),
      .tag_out(sat_out)
    );
  end

  always_comb begin
    for (int c = 0; c < NUM_MEANS; c++) begin
      mem_nxt[c] = '0;
    end
    for (int c = 0; c < NL; c++) begin
      if (c < int'(cfg.cls_cnt)) begin
        mem_nxt[c] = usat[c] ? ONE : {1'b0, uq[c]};
      end
    end
  end

  // Output register.
  logic [F:0] mem_r [NUM_MEANS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mem_r <= mem_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_member_zero  = mem_r[0];
  assign out_member_one   = mem_r[1];
  assign out_member_two   = mem_r[2];
  assign out_member_three = mem_r[3];

  // Membership zero never exceeds one.
  a_member_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_member_zero <= ONE))
    else $error("membership above one");

  // A single class in use leaves the other memberships at zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cfg.cls_cnt == COUNT_BITS'(1))) |->
      (out_member_one == '0 && out_member_two == '0 && out_member_three == '0))
    else $error("unused class has a nonzero membership");

  // The input side is stalled only while a finished word waits at a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && vld_r[LAT-1]))
    else $error("input stalled without a waiting result");

endmodule
